// File: rtl/dcc_pkg.sv
package dcc_pkg;

    // Packet buffer sizing
    localparam int MaxBytes = 6;
    localparam int AddrW    = $clog2(MaxBytes);
    localparam int CntW     = $clog2(MaxBytes + 2);
    localparam int CmpW     = (CntW > 3) ? CntW : 3;

    // Framing constants
    localparam int PreW           = 4;
    localparam int PreambleNeeded = 10;
    localparam int BitsPerByte    = 8;

    // Configuration register indexes
    localparam logic [2:0] CfgOneMin   = 3'd0;
    localparam logic [2:0] CfgOneMax   = 3'd1;
    localparam logic [2:0] CfgZeroMin  = 3'd2;
    localparam logic [2:0] CfgZeroMax  = 3'd3;
    localparam logic [2:0] CfgMinBytes = 3'd4;

    // Configuration reset values
    localparam logic [15:0] RstOneMin   = 16'd52;
    localparam logic [15:0] RstOneMax   = 16'd64;
    localparam logic [15:0] RstZeroMin  = 16'd90;
    localparam logic [15:0] RstZeroMax  = 16'd10000;
    localparam logic [2:0]  RstMinBytes = 3'd3;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_TIMING = 2'd1,
        KIND_COUNT  = 2'd2
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic  load_period;
        logic  go_idle;
        logic  pre_start;
        logic  pre_inc;
        logic  data_start;
        logic  data_shift;
        logic  byte_next;
        logic  clear_bytes;
        logic  drain_clear;
        logic  drain_next;
        logic  drain_read;
        logic  push;
        t_kind push_kind;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bit_one;
        logic bit_valid;
        logic pre_done;
        logic byte_done;
        logic count_ok;
        logic drain_last;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/dcc_if.sv
interface dcc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] bit_period;

    modport source (output valid, output bit_period, input ready);
    modport sink   (input valid, input bit_period, output ready);
endinterface

interface dcc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [2:0] byte_index;
    logic       last;

    modport source (output valid, output kind, output byte_value, output byte_index,
                    output last, input ready);
    modport sink   (input valid, input kind, input byte_value, input byte_index,
                    input last, output ready);
endinterface

interface dcc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/dcc_ram.sv
module dcc_ram #(
    parameter int Width = 8,
    parameter int Depth = 6
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(Depth)-1:0] i_wr_addr,
    input  logic [Width-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(Depth)-1:0] i_rd_addr,
    output logic [Width-1:0]         o_rd_data
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/dcc_datapath.sv
module dcc_datapath
    import dcc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    dcc_in_if.sink       i_in,
    dcc_out_if.source    o_out,
    dcc_cfg_if.sink      i_cfg,
    input  t_dp_cmd      i_cmd,
    output t_dp_sts      o_sts
);

    logic [15:0]      r_one_min, r_one_max, r_zero_min, r_zero_max;
    logic [2:0]       r_min_bytes;
    logic [15:0]      r_period;
    logic [7:0]       r_shift;
    logic [PreW-1:0]  r_pre;
    logic [3:0]       r_bits;
    logic [CntW-1:0]  r_bytes;
    logic [AddrW-1:0] r_drain_idx;

    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [7:0]       r_out_value;
    logic [2:0]       r_out_index;
    logic             r_out_last;

    logic             is_one;
    logic             is_zero;
    logic [7:0]       n_shift;
    logic             store_wr;
    logic [7:0]       rd_data;
    logic             drain_last;

    assign i_cfg.ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_min   <= RstOneMin;
            r_one_max   <= RstOneMax;
            r_zero_min  <= RstZeroMin;
            r_zero_max  <= RstZeroMax;
            r_min_bytes <= RstMinBytes;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CfgOneMin:   r_one_min   <= i_cfg.data;
                CfgOneMax:   r_one_max   <= i_cfg.data;
                CfgZeroMin:  r_zero_min  <= i_cfg.data;
                CfgZeroMax:  r_zero_max  <= i_cfg.data;
                CfgMinBytes: r_min_bytes <= i_cfg.data[2:0];
                default: ;
            endcase
        end
    end

    // Classify the latched period: one window wins over zero window
    assign is_one  = (r_period >= r_one_min) && (r_period <= r_one_max);
    assign is_zero = (r_period >= r_zero_min) && (r_period <= r_zero_max);
    assign n_shift = {r_shift[6:0], is_one};

    assign store_wr   = i_cmd.data_shift && (r_bits >= 4'(BitsPerByte - 1))
                        && (r_bytes < CntW'(MaxBytes));
    assign drain_last = (CntW'(r_drain_idx) + CntW'(1)) == r_bytes;

    // Advance framing counters and shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_pre       <= '0;
            r_bits      <= '0;
            r_bytes     <= '0;
            r_drain_idx <= '0;
        end else begin
            if (i_cmd.go_idle) begin
                r_shift <= '0;
                r_pre   <= '0;
                r_bits  <= '0;
                r_bytes <= '0;
            end
            if (i_cmd.pre_start) begin
                r_pre  <= PreW'(1);
                r_bits <= '0;
            end
            if (i_cmd.pre_inc && (r_pre != '1)) begin
                r_pre <= r_pre + PreW'(1);
            end
            if (i_cmd.data_start) begin
                r_shift <= '0;
                r_bits  <= '0;
                r_bytes <= '0;
            end
            if (i_cmd.data_shift) begin
                r_shift <= n_shift;
                r_bits  <= r_bits + 4'd1;
                if ((r_bits >= 4'(BitsPerByte - 1)) && (r_bytes <= CntW'(MaxBytes))) begin
                    r_bytes <= r_bytes + CntW'(1);
                end
            end
            if (i_cmd.byte_next) begin
                r_shift <= '0;
                r_bits  <= '0;
            end
            if (i_cmd.clear_bytes) begin
                r_bytes <= '0;
            end
            if (i_cmd.drain_clear) begin
                r_drain_idx <= '0;
            end else if (i_cmd.drain_next) begin
                r_drain_idx <= r_drain_idx + AddrW'(1);
            end
        end
    end

    // Latch the accepted period
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_period) begin
            r_period <= i_in.bit_period;
        end
    end

    dcc_ram #(
        .Width (8),
        .Depth (MaxBytes)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr),
        .i_wr_addr (AddrW'(r_bytes)),
        .i_wr_data (n_shift),
        .i_rd_en   (i_cmd.drain_read),
        .i_rd_addr (r_drain_idx),
        .o_rd_data (rd_data)
    );

    // Output register: load on push, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_kind <= i_cmd.push_kind;
            if (i_cmd.push_kind == KIND_BYTE) begin
                r_out_value <= rd_data;
                r_out_index <= 3'(r_drain_idx);
                r_out_last  <= drain_last;
            end else begin
                r_out_value <= '0;
                r_out_index <= '0;
                r_out_last  <= 1'b1;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out_kind;
    assign o_out.byte_value = r_out_value;
    assign o_out.byte_index = r_out_index;
    assign o_out.last       = r_out_last;

    // Report status to the controller
    always_comb begin
        o_sts.bit_one    = is_one;
        o_sts.bit_valid  = is_one || is_zero;
        o_sts.pre_done   = r_pre >= PreW'(PreambleNeeded - 1);
        o_sts.byte_done  = r_bits >= 4'(BitsPerByte - 1);
        o_sts.count_ok   = (CmpW'(r_bytes) >= CmpW'(r_min_bytes))
                           && (r_bytes <= CntW'(MaxBytes)) && (r_bytes != '0);
        o_sts.drain_last = drain_last;
        o_sts.out_free   = !r_out_valid || o_out.ready;
    end

endmodule

// File: rtl/dcc_ctrl.sv
module dcc_ctrl
    import dcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_WAIT,
        ST_STEP,
        ST_DRAIN_RD,
        ST_DRAIN_WR
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PREAMBLE,
        PH_START,
        PH_DATA,
        PH_INTERBIT
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    assign o_in_ready = (r_state == ST_WAIT);

    // Sequence one bit per transaction, then drain a finished packet
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        o_cmd.push_kind = KIND_BYTE;
        case (r_state)
            ST_WAIT: begin
                if (i_in_valid) begin
                    o_cmd.load_period = 1'b1;
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (!i_sts.bit_valid) begin
                    // timing error: report only when a packet was under way
                    if (r_phase == PH_IDLE) begin
                        n_state = ST_WAIT;
                    end else if (i_sts.out_free) begin
                        o_cmd.go_idle   = 1'b1;
                        o_cmd.push      = 1'b1;
                        o_cmd.push_kind = KIND_TIMING;
                        n_phase = PH_IDLE;
                        n_state = ST_WAIT;
                    end
                end else begin
                    n_state = ST_WAIT;
                    case (r_phase)
                        PH_IDLE: begin
                            if (i_sts.bit_one) begin
                                o_cmd.pre_start = 1'b1;
                                n_phase = PH_PREAMBLE;
                            end
                        end
                        PH_PREAMBLE: begin
                            if (i_sts.bit_one) begin
                                o_cmd.pre_inc = 1'b1;
                                if (i_sts.pre_done) begin
                                    n_phase = PH_START;
                                end
                            end else begin
                                o_cmd.go_idle = 1'b1;
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_START: begin
                            o_cmd.pre_inc = 1'b1;
                            if (!i_sts.bit_one) begin
                                o_cmd.data_start = 1'b1;
                                n_phase = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            o_cmd.data_shift = 1'b1;
                            if (i_sts.byte_done) begin
                                n_phase = PH_INTERBIT;
                            end
                        end
                        PH_INTERBIT: begin
                            if (!i_sts.bit_one) begin
                                o_cmd.byte_next = 1'b1;
                                n_phase = PH_DATA;
                            end else if (i_sts.count_ok) begin
                                o_cmd.pre_start   = 1'b1;
                                o_cmd.drain_clear = 1'b1;
                                n_phase = PH_PREAMBLE;
                                n_state = ST_DRAIN_RD;
                            end else if (i_sts.out_free) begin
                                o_cmd.go_idle   = 1'b1;
                                o_cmd.push      = 1'b1;
                                o_cmd.push_kind = KIND_COUNT;
                                n_phase = PH_IDLE;
                            end else begin
                                n_state = ST_STEP;
                            end
                        end
                        default: begin
                            o_cmd.go_idle = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            ST_DRAIN_RD: begin
                o_cmd.drain_read = 1'b1;
                n_state = ST_DRAIN_WR;
            end
            ST_DRAIN_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = KIND_BYTE;
                    if (i_sts.drain_last) begin
                        o_cmd.clear_bytes = 1'b1;
                        n_state = ST_WAIT;
                    end else begin
                        o_cmd.drain_next = 1'b1;
                        n_state = ST_DRAIN_RD;
                    end
                end
            end
            default: n_state = ST_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT;
            r_phase <= PH_IDLE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

// File: rtl/dcc_packet_deframer.sv
// DCC packet deframer.
// i_in carries one measured bit period per transaction. Each period is
// classified as a one bit, a zero bit or a timing error against the
// configured windows, and drives preamble, start, data and interbit framing.
// o_out carries results: packet bytes in order (byte_index, last on the
// final byte), a timing error, or a byte count error (value 0, last 1).
// i_cfg writes the window limits and minimum packet length by register
// index; the write is always taken and should only be issued while idle.
// Each bit period is latched, then classified and applied to the framing;
// the input is ready again after that unless a result must wait for a free
// output register. A packet end bit then drains the packet buffer: each
// byte is one registered read of the buffer, then a push to the output.
// Results sit in a single output register, so the next period may be
// accepted while a result waits; when the receiver stalls, a new result
// holds the block until the register frees.
// Reset (synchronous, active low) returns framing to idle, restores the
// default windows and empties the output register. The packet buffer is not
// cleared; only bytes written in the current packet are read.
module dcc_packet_deframer
    import dcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcc_in_if.sink    i_in,
    dcc_out_if.source o_out,
    dcc_cfg_if.sink   i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dcc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

// File: rtl/dcc_checker.sv
module dcc_checker
    import dcc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [7:0] i_out_value,
    input logic [2:0] i_out_index,
    input logic       i_out_last
);

    // Stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_value) && $stable(i_out_index) && $stable(i_out_last))
        else $error("stalled result changed");

    // Only defined result kinds leave the block
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_kind == KIND_BYTE) || (i_out_kind == KIND_TIMING)
            || (i_out_kind == KIND_COUNT))
        else $error("undefined result kind");

    // Error results carry no byte and close the transaction group
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind != KIND_BYTE) |->
            (i_out_value == 8'd0) && (i_out_index == 3'd0) && i_out_last)
        else $error("error result with payload");

    // No result right after reset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result pending after reset");

endmodule

bind dcc_packet_deframer dcc_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_value (o_out.byte_value),
    .i_out_index (o_out.byte_index),
    .i_out_last  (o_out.last)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dcc_pkg::*;

    localparam int ClkPeriod  = 10;
    localparam int HoldCycles = 400;
    localparam int TailCycles = 24;

    typedef enum logic [2:0] {
        FP_IDLE,
        FP_PREAMBLE,
        FP_START,
        FP_DATA,
        FP_INTERBIT
    } t_frame_phase;

    typedef enum logic [1:0] {
        BIT_ZERO,
        BIT_ONE,
        BIT_BAD
    } t_bit_class;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic [2:0]  index;
        logic        last;
    } t_result;

    // Track the framing state and hold the packet results still to come
    class packet_tracker;
        logic [15:0]     one_min   = RstOneMin;
        logic [15:0]     one_max   = RstOneMax;
        logic [15:0]     zero_min  = RstZeroMin;
        logic [15:0]     zero_max  = RstZeroMax;
        logic [2:0]      min_bytes = RstMinBytes;
        t_frame_phase    phase     = FP_IDLE;
        logic [7:0]      shifter   = '0;
        logic [PreW-1:0] pre_ones  = '0;
        logic [3:0]      bit_cnt   = '0;
        logic [CntW-1:0] byte_cnt  = '0;
        logic [7:0]      store [MaxBytes];
        t_result         pending [$];
        int              produced   = 0;
        int              mismatches = 0;

        function t_bit_class classify(logic [15:0] p);
            if (p >= one_min && p <= one_max) return BIT_ONE;
            if (p >= zero_min && p <= zero_max) return BIT_ZERO;
            return BIT_BAD;
        endfunction

        function void clear_frame();
            phase    = FP_IDLE;
            shifter  = '0;
            pre_ones = '0;
            bit_cnt  = '0;
            byte_cnt = '0;
        endfunction

        function void push(t_kind k, logic [7:0] v, logic [2:0] idx, logic l);
            t_result r;
            r.kind  = k;
            r.value = v;
            r.index = idx;
            r.last  = l;
            pending.push_back(r);
            produced++;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] d);
            case (idx)
                CfgOneMin:   one_min   = d;
                CfgOneMax:   one_max   = d;
                CfgZeroMin:  zero_min  = d;
                CfgZeroMax:  zero_max  = d;
                CfgMinBytes: min_bytes = d[2:0];
                default: ;
            endcase
        endfunction

        // Advance the framing state by one accepted bit period
        function void note_period(logic [15:0] p);
            t_bit_class c;
            logic       one;
            c   = classify(p);
            one = (c == BIT_ONE);
            if (c == BIT_BAD) begin
                // a bad period only matters once a frame has begun
                if (phase != FP_IDLE) begin
                    clear_frame();
                    push(KIND_TIMING, 8'd0, 3'd0, 1'b1);
                end
                return;
            end
            case (phase)
                FP_IDLE: begin
                    if (one) begin
                        phase    = FP_PREAMBLE;
                        pre_ones = PreW'(1);
                    end
                end
                FP_PREAMBLE: begin
                    if (one) begin
                        if (pre_ones < 15) pre_ones++;
                        if (pre_ones >= PreambleNeeded) phase = FP_START;
                    end else begin
                        clear_frame();
                    end
                end
                FP_START: begin
                    if (pre_ones < 15) pre_ones++;
                    if (!one) begin
                        phase    = FP_DATA;
                        shifter  = '0;
                        bit_cnt  = '0;
                        byte_cnt = '0;
                    end
                end
                FP_DATA: begin
                    shifter = {shifter[6:0], one};
                    bit_cnt++;
                    if (bit_cnt >= BitsPerByte) begin
                        phase = FP_INTERBIT;
                        if (byte_cnt < MaxBytes) store[byte_cnt] = shifter;
                        // saturate one past the buffer size
                        if (byte_cnt <= MaxBytes) byte_cnt++;
                    end
                end
                FP_INTERBIT: begin
                    if (one) begin
                        if (byte_cnt >= min_bytes && byte_cnt <= MaxBytes && byte_cnt > 0) begin
                            for (int i = 0; i < byte_cnt; i++)
                                push(KIND_BYTE, store[i], 3'(i), (i + 1 == byte_cnt));
                            phase    = FP_PREAMBLE;
                            pre_ones = PreW'(1);
                            bit_cnt  = '0;
                            byte_cnt = '0;
                        end else begin
                            clear_frame();
                            push(KIND_COUNT, 8'd0, 3'd0, 1'b1);
                        end
                    end else begin
                        phase   = FP_DATA;
                        bit_cnt = '0;
                        shifter = '0;
                    end
                end
                default: clear_frame();
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Compare one accepted result with the oldest one predicted
        task check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d value %0h index %0d",
                                          got.kind, got.value, got.index));
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, predicted %0d", got.kind, want.kind));
            if (got.value !== want.value)
                report_mismatch($sformatf("byte_value %0h, predicted %0h",
                                          got.value, want.value));
            if (got.index !== want.index)
                report_mismatch($sformatf("byte_index %0d, predicted %0d",
                                          got.index, want.index));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, predicted %0b", got.last, want.last));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    dcc_in_if  in_bus ();
    dcc_out_if out_bus ();
    dcc_cfg_if cfg_bus ();

    dcc_packet_deframer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    packet_tracker    board = new();
    t_result          seen_result;
    int               items_sent = 0;
    bit               calm       = 1'b0;
    bit               hold_req   = 1'b0;
    int               seq_pos    = 0;
    int               corrupt_at = -1;

    initial begin
        i_clk = 1'b0;
        forever #(ClkPeriod / 2) i_clk = ~i_clk;
    end

    // End the run if traffic stops moving
    initial begin
        #20ms;
        $display("dcc_packet_deframer verification failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_one();
        if (board.one_min <= board.one_max)
            return 16'($urandom_range(board.one_max, board.one_min));
        return 16'($urandom());
    endfunction

    // Prefer a period that really classifies as zero when windows overlap
    function automatic logic [15:0] pick_zero();
        logic [15:0] p;
        if (board.zero_min > board.zero_max) return 16'($urandom());
        p = 16'($urandom_range(board.zero_max, board.zero_min));
        for (int t = 0; t < 4 && board.classify(p) != BIT_ZERO; t++)
            p = 16'($urandom_range(board.zero_max, board.zero_min));
        return p;
    endfunction

    // Offer one bit period and hold it until the transaction completes
    task automatic send_period(input logic [15:0] p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.bit_period <= p;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        board.note_period(p);
        items_sent++;
    endtask

    task automatic send_bit(input logic b);
        logic [15:0] p;
        if (seq_pos == corrupt_at) begin
            p = 16'($urandom());
            for (int t = 0; t < 16 && board.classify(p) != BIT_BAD; t++)
                p = 16'($urandom());
        end else begin
            p = b ? pick_one() : pick_zero();
        end
        seq_pos++;
        send_period(p);
    endtask

    // Drop valid and wait for every predicted result, then let the block go quiet
    task automatic settle();
        in_bus.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
    endtask

    task automatic apply_windows(input logic [15:0] omin, input logic [15:0] omax,
                                 input logic [15:0] zmin, input logic [15:0] zmax,
                                 input logic [2:0] mb);
        logic [15:0] vals [5];
        logic [2:0]  regs [5];
        vals = '{omin, omax, zmin, zmax, {13'd0, mb}};
        regs = '{CfgOneMin, CfgOneMax, CfgZeroMin, CfgZeroMax, CfgMinBytes};
        for (int k = 0; k < 5; k++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= regs[k];
            cfg_bus.data  <= vals[k];
            do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
            board.set_reg(regs[k], vals[k]);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly framed packets with random bytes, the rest loose noise
    task automatic run_traffic(input int budget, input int want);
        int         first_item;
        int         first_res;
        int         r;
        int         pre;
        int         nbytes;
        logic [7:0] data;
        first_item = items_sent;
        first_res  = board.produced;
        while (items_sent - first_item < budget || board.produced - first_res < want) begin
            calm = ($urandom_range(0, 5) == 0);
            r    = $urandom_range(0, 99);
            if (r < 75) begin
                pre = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 9) : $urandom_range(10, 17);
                r   = $urandom_range(0, 99);
                if (r < 10)      nbytes = $urandom_range(1, 2);
                else if (r < 80) nbytes = $urandom_range(3, MaxBytes);
                else             nbytes = $urandom_range(MaxBytes + 1, MaxBytes + 2);
                seq_pos    = 0;
                corrupt_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, pre + nbytes * 9) : -1;
                repeat (pre) send_bit(1'b1);
                send_bit(1'b0);
                for (int b = 0; b < nbytes; b++) begin
                    data = 8'($urandom_range(0, 255));
                    for (int k = 7; k >= 0; k--) send_bit(data[k]);
                    // zero separator between bytes, one to end the packet
                    send_bit(b == nbytes - 1);
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, 99);
                    if (r < 50)      send_period(16'($urandom_range(0, 65535)));
                    else if (r < 75) send_period(pick_one());
                    else             send_period(pick_zero());
                end
            end
        end
        calm = 1'b0;
    endtask

    // Accept results with random stalls, or a long hold-off on request
    initial begin
        int   idle_left;
        logic rdy;
        idle_left = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_bus.ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (idle_left > 0) begin
                    rdy = 1'b0;
                    idle_left--;
                end else begin
                    rdy = 1'b1;
                    if (!calm && $urandom_range(0, 99) < 30) idle_left = pick_gap();
                end
                out_bus.ready <= rdy;
            end
        end
    end

    // Check every result transaction
    always @(posedge i_clk) begin
        if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            seen_result.kind  = t_kind'(out_bus.kind);
            seen_result.value = out_bus.byte_value;
            seen_result.index = out_bus.byte_index;
            seen_result.last  = out_bus.last;
            board.check_result(seen_result);
        end
    end

    initial begin
        logic [15:0] edge_periods [];
        edge_periods = '{16'd0, 16'd65535, 16'd51, 16'd52, 16'd100, 16'd64, 16'd65,
                         16'd89, 16'd90, 16'd10000, 16'd10001, 16'd52, 16'd53, 16'd54,
                         16'd65535, 16'd63, 16'd0};
        i_rst_n           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.bit_period <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= '0;
        cfg_bus.data      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Window edges, silent idle cases and errors out of a preamble
        foreach (edge_periods[k]) send_period(edge_periods[k]);
        run_traffic(12, 2);
        settle();

        // Wide windows, single byte packets legal; stall the receiver for a long stretch
        apply_windows(16'd40, 16'd70, 16'd80, 16'd65535, 3'd1);
        hold_req = 1'b1;
        run_traffic(12, 2);
        settle();

        // Lowest one window, full packets only
        apply_windows(16'd0, 16'd0, 16'd1, 16'd65535, 3'(MaxBytes));
        run_traffic(12, 1);
        settle();

        // Top one window, zero window from period zero, minimum of zero bytes
        apply_windows(16'd65000, 16'd65535, 16'd0, 16'd64999, 3'd0);
        run_traffic(12, 2);
        settle();

        // Minimum beyond the buffer: every packet is a count error
        apply_windows(16'd30, 16'd40, 16'd50, 16'd300, 3'd7);
        run_traffic(12, 1);
        settle();

        // Both windows empty: no frame can begin
        apply_windows(16'd500, 16'd100, 16'd9000, 16'd8000, 3'd3);
        run_traffic(10, 0);
        settle();

        // Overlapping windows: the one window wins
        apply_windows(16'd100, 16'd300, 16'd200, 16'd5000, 3'd2);
        run_traffic(12, 2);
        settle();

        apply_windows(RstOneMin, RstOneMax, RstZeroMin, RstZeroMax, RstMinBytes);
        run_traffic(10, 2);
        settle();

        if (board.mismatches == 0) begin
            $display("dcc_packet_deframer verification clean");
        end else begin
            $display("dcc_packet_deframer verification failed");
        end
        $finish;
    end

endmodule
